FILE: rtl/core/bit_field_stream_buffer_top_defines.svh
// Assertion helpers for the bit field stream buffer.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef BIT_FIELD_STREAM_BUFFER_TOP_DEFINES_SVH
`define BIT_FIELD_STREAM_BUFFER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BFSB_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bfsb: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BFSB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bfsb: next-cycle check failed");

`endif

FILE: rtl/core/bfsb_pkg.sv
`default_nettype none

package bfsb_pkg;

    // Default sizing of the store and of the longest field.
    localparam int STORE_BYTES_DEF    = 4096;
    localparam int MAX_FIELD_BITS_DEF = 32;

    // Payload widths of the stream channels.
    localparam int OP_W     = 2;
    localparam int VALUE_W  = 32;
    localparam int LENGTH_W = 6;
    localparam int POS_W    = 16;
    localparam int STATUS_W = 2;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam int CAP_W      = 13;
    localparam int MODE_W     = 2;
    localparam logic [CAP_W-1:0] CAP_RESET = 13'd4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAPACITY = 1'b0,
        REG_MODE     = 1'b1
    } reg_idx_t;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_SEEK  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_RW   = 2'd0,
        MODE_RO   = 2'd1,
        MODE_WO   = 2'd2,
        MODE_NONE = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_ROOM  = 2'd1,
        ST_PAST_END = 2'd2,
        ST_FORBID   = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/core/bfsb_if.sv
`default_nettype none

// Command channel: one operation per transfer.
interface bfsb_in_if;
    logic                               valid;
    logic                               ready;
    logic [bfsb_pkg::OP_W-1:0]          operation;
    logic [bfsb_pkg::VALUE_W-1:0]       write_value;
    logic [bfsb_pkg::LENGTH_W-1:0]      field_length;
    logic [bfsb_pkg::POS_W-1:0]         new_position;

    modport source (output valid, output operation, output write_value,
                    output field_length, output new_position, input ready);
    modport sink   (input valid, input operation, input write_value,
                    input field_length, input new_position, output ready);
endinterface

// Result channel: one result per command.
interface bfsb_out_if;
    logic                               valid;
    logic                               ready;
    logic [bfsb_pkg::VALUE_W-1:0]       read_value;
    logic [bfsb_pkg::POS_W-1:0]         cursor_position;
    logic [bfsb_pkg::POS_W-1:0]         data_size_bits;
    logic [bfsb_pkg::STATUS_W-1:0]      status;

    modport source (output valid, output read_value, output cursor_position,
                    output data_size_bits, output status, input ready);
    modport sink   (input valid, input read_value, input cursor_position,
                    input data_size_bits, input status, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/bfsb_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module bfsb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/bfsb_field_unit.sv
`default_nettype none

// Extracts a field from a pair of adjacent store words and merges a new
// field into the same pair. The field starts at bit offset of the low word.
module bfsb_field_unit #(
    parameter int WORD_BITS = 32,
    parameter int LEN_W     = 6
) (
    input  wire logic [WORD_BITS-1:0]         lo_word,
    input  wire logic [WORD_BITS-1:0]         hi_word,
    input  wire logic [$clog2(WORD_BITS)-1:0] offset,
    input  wire logic [LEN_W-1:0]             len,
    input  wire logic [bfsb_pkg::VALUE_W-1:0] wval,
    output logic      [bfsb_pkg::VALUE_W-1:0] rd_value,
    output logic      [WORD_BITS-1:0]         new_lo,
    output logic      [WORD_BITS-1:0]         new_hi
);

    localparam int PAIR_BITS = 2 * WORD_BITS;

    logic [PAIR_BITS-1:0] pair;
    logic [PAIR_BITS-1:0] field_mask;
    logic [PAIR_BITS-1:0] rd_field;
    logic [PAIR_BITS-1:0] wr_field;
    logic [PAIR_BITS-1:0] merged;

    // Low len bits set; len never exceeds one word, so the shift stays in range.
    assign pair       = {hi_word, lo_word};
    assign field_mask = ~({PAIR_BITS{1'b1}} << len);

    // Read path: align the field to bit zero and zero the bits above it.
    assign rd_field = (pair >> offset) & field_mask;
    assign rd_value = bfsb_pkg::VALUE_W'(rd_field);

    // Write path: bits of the value beyond 32 come in as zeros.
    assign wr_field = PAIR_BITS'(wval) & field_mask;
    assign merged   = (pair & ~(field_mask << offset)) | (wr_field << offset);
    assign new_lo   = merged[WORD_BITS-1:0];
    assign new_hi   = merged[PAIR_BITS-1:WORD_BITS];

endmodule

`default_nettype wire

FILE: rtl/core/bit_field_stream_buffer_top.sv
`default_nettype none

`include "bit_field_stream_buffer_top_defines.svh"

// Bit field stream buffer. Each command is handled in turn: in the cycle it is
// transferred, the even and odd word banks are read at the two words that the
// bit cursor touches; in the next cycle the field is extracted or merged, the
// pair of words is written back and the result is loaded into the output
// register. A new command is taken in the cycle after that, or later while
// the result register is still held by the sink. The rate is set by the
// registered read data of the banks followed by the write back. The store
// content is undefined after reset and needs no clearing pass; only bits that
// were written since the last clear can be read. Configuration writes take
// effect at once and are expected only while the block is idle.
module bit_field_stream_buffer_top #(
    parameter int STORE_BYTES    = bfsb_pkg::STORE_BYTES_DEF,
    parameter int MAX_FIELD_BITS = bfsb_pkg::MAX_FIELD_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    bfsb_in_if.sink                                in_ch,
    bfsb_out_if.source                             out_ch,
    input  wire logic                              cfg_we,
    input  wire logic [bfsb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bfsb_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // Words are wide enough that any field touches at most two of them.
    localparam int WORD_BITS  = (MAX_FIELD_BITS <= 8)  ? 8  :
                                (MAX_FIELD_BITS <= 16) ? 16 :
                                (MAX_FIELD_BITS <= 32) ? 32 : 64;
    localparam int WSH        = $clog2(WORD_BITS);
    localparam int STORE_BITS = STORE_BYTES * 8;
    localparam int NUM_WORDS  = STORE_BITS / WORD_BITS;
    localparam int HALF_WORDS = (NUM_WORDS + 1) / 2;
    localparam int BANK_DEPTH = (HALF_WORDS < 2) ? 2 : HALF_WORDS;
    localparam int AW         = $clog2(BANK_DEPTH);
    localparam int LEN_W      = $clog2(MAX_FIELD_BITS + 1);
    localparam logic [16:0] STORE_LIM = 17'(STORE_BYTES);

    localparam int PW = bfsb_pkg::POS_W;
    localparam int VW = bfsb_pkg::VALUE_W;

    // Control and configuration state.
    bfsb_pkg::state_t                 state_reg, state_next;
    logic [PW-1:0]                    cursor_reg, cursor_next;
    logic [PW-1:0]                    valid_reg, valid_next;
    logic [bfsb_pkg::CAP_W-1:0]       cap_reg, cap_next;
    bfsb_pkg::mode_t                  mode_reg, mode_next;
    logic                             out_valid_reg, out_valid_next;

    // Command held for the execute cycle.
    bfsb_pkg::op_t                    op_reg;
    logic [VW-1:0]                    wval_reg;
    logic [LEN_W-1:0]                 len_reg;
    logic [PW-1:0]                    target_reg;

    // Result register.
    logic [VW-1:0]                    rval_reg, rval_next;
    bfsb_pkg::status_t                status_reg, status_next;

    logic                             in_ready;
    logic                             in_fire;
    logic                             exec_en;
    logic [LEN_W-1:0]                 len_sat;

    logic [16:0]                      word_lo, word_hi, even_word, odd_word;
    logic [AW-1:0]                    even_addr, odd_addr;
    logic [WORD_BITS-1:0]             even_rdata, odd_rdata;
    logic [WORD_BITS-1:0]             lo_data, hi_data;
    logic [WORD_BITS-1:0]             new_lo, new_hi;
    logic [WORD_BITS-1:0]             even_wdata, odd_wdata;
    logic [VW-1:0]                    rd_value;
    logic                             store_we;

    logic [16:0]                      cap_sat, cap_bits, end_pos;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bfsb_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = bfsb_pkg::S_EXEC;
                end
            end
            bfsb_pkg::S_EXEC:
            begin
                state_next = bfsb_pkg::S_IDLE;
            end
            default:
            begin
                state_next = bfsb_pkg::S_IDLE;
            end
        endcase
    end

    // State outputs. A command is taken only when the result register is
    // free by the time the command finishes.
    always_comb
    begin
        in_ready = 1'b0;
        exec_en  = 1'b0;
        case (state_reg)
            bfsb_pkg::S_IDLE:
            begin
                in_ready = !out_valid_reg || out_ch.ready;
            end
            bfsb_pkg::S_EXEC:
            begin
                exec_en = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign in_fire     = in_ch.valid && in_ready;
    assign in_ch.ready = in_ready;

    // Field length saturates at the longest supported field.
    always_comb
    begin
        if ({1'b0, in_ch.field_length} > 7'(MAX_FIELD_BITS))
        begin
            len_sat = LEN_W'(MAX_FIELD_BITS);
        end
        else
        begin
            len_sat = LEN_W'(in_ch.field_length);
        end
    end

    // Capture the command on transfer.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg     <= bfsb_pkg::op_t'(in_ch.operation);
            wval_reg   <= in_ch.write_value;
            len_reg    <= len_sat;
            target_reg <= in_ch.new_position;
        end
    end

    // Word pair under the cursor, split over the even and odd banks.
    always_comb
    begin
        word_lo   = 17'(cursor_reg >> WSH);
        word_hi   = word_lo + 17'd1;
        even_word = word_lo[0] ? word_hi : word_lo;
        odd_word  = word_lo[0] ? word_lo : word_hi;
        even_addr = AW'(even_word >> 1);
        odd_addr  = AW'(odd_word >> 1);
    end

    bfsb_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (BANK_DEPTH)
    ) u_even_bank (
        .clk   (clk),
        .we    (store_we),
        .waddr (even_addr),
        .wdata (even_wdata),
        .re    (in_fire),
        .raddr (even_addr),
        .rdata (even_rdata)
    );

    bfsb_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (BANK_DEPTH)
    ) u_odd_bank (
        .clk   (clk),
        .we    (store_we),
        .waddr (odd_addr),
        .wdata (odd_wdata),
        .re    (in_fire),
        .raddr (odd_addr),
        .rdata (odd_rdata)
    );

    // The cursor holds still between read and write back, so the same word
    // selection applies to both.
    assign lo_data = word_lo[0] ? odd_rdata : even_rdata;
    assign hi_data = word_lo[0] ? even_rdata : odd_rdata;

    bfsb_field_unit #(
        .WORD_BITS (WORD_BITS),
        .LEN_W     (LEN_W)
    ) u_field_unit (
        .lo_word  (lo_data),
        .hi_word  (hi_data),
        .offset   (cursor_reg[WSH-1:0]),
        .len      (len_reg),
        .wval     (wval_reg),
        .rd_value (rd_value),
        .new_lo   (new_lo),
        .new_hi   (new_hi)
    );

    assign even_wdata = word_lo[0] ? new_hi : new_lo;
    assign odd_wdata  = word_lo[0] ? new_lo : new_hi;

    // Capacity in bits, with the byte count limited to the store size.
    always_comb
    begin
        if (17'(cap_reg) > STORE_LIM)
        begin
            cap_sat = STORE_LIM;
        end
        else
        begin
            cap_sat = 17'(cap_reg);
        end
        cap_bits = {cap_sat[13:0], 3'b000};
        end_pos  = {1'b0, cursor_reg} + 17'(len_reg);
    end

    // Execute: checks, cursor and size update, result.
    always_comb
    begin
        cursor_next = cursor_reg;
        valid_next  = valid_reg;
        rval_next   = rval_reg;
        status_next = status_reg;
        store_we    = 1'b0;
        if (exec_en)
        begin
            rval_next   = '0;
            status_next = bfsb_pkg::ST_OK;
            case (op_reg)
                bfsb_pkg::OP_WRITE:
                begin
                    if (mode_reg inside {bfsb_pkg::MODE_RO, bfsb_pkg::MODE_NONE})
                    begin
                        status_next = bfsb_pkg::ST_FORBID;
                    end
                    else if (end_pos > cap_bits)
                    begin
                        status_next = bfsb_pkg::ST_NO_ROOM;
                    end
                    else
                    begin
                        store_we    = 1'b1;
                        cursor_next = end_pos[PW-1:0];
                        if (end_pos[PW-1:0] > valid_reg)
                        begin
                            valid_next = end_pos[PW-1:0];
                        end
                    end
                end
                bfsb_pkg::OP_READ:
                begin
                    if (mode_reg inside {bfsb_pkg::MODE_WO, bfsb_pkg::MODE_NONE})
                    begin
                        status_next = bfsb_pkg::ST_FORBID;
                    end
                    else if (end_pos > {1'b0, valid_reg})
                    begin
                        status_next = bfsb_pkg::ST_PAST_END;
                    end
                    else
                    begin
                        rval_next   = rd_value;
                        cursor_next = end_pos[PW-1:0];
                    end
                end
                bfsb_pkg::OP_SEEK:
                begin
                    if (target_reg > valid_reg)
                    begin
                        status_next = bfsb_pkg::ST_PAST_END;
                    end
                    else if ({1'b0, target_reg} > cap_bits)
                    begin
                        status_next = bfsb_pkg::ST_NO_ROOM;
                    end
                    else
                    begin
                        cursor_next = target_reg;
                    end
                end
                bfsb_pkg::OP_CLEAR:
                begin
                    cursor_next = '0;
                    valid_next  = '0;
                end
                default:
                begin
                    status_next = bfsb_pkg::ST_OK;
                end
            endcase
        end
    end

    // Configuration writes; an index beyond the list is ignored.
    always_comb
    begin
        cap_next  = cap_reg;
        mode_next = mode_reg;
        if (cfg_we)
        begin
            case (bfsb_pkg::reg_idx_t'(cfg_index))
                bfsb_pkg::REG_CAPACITY:
                begin
                    cap_next = cfg_data[bfsb_pkg::CAP_W-1:0];
                end
                bfsb_pkg::REG_MODE:
                begin
                    mode_next = bfsb_pkg::mode_t'(cfg_data[bfsb_pkg::MODE_W-1:0]);
                end
                default:
                begin
                    cap_next = cap_reg;
                end
            endcase
        end
    end

    // Result register handshake.
    always_comb
    begin
        if (exec_en)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bfsb_pkg::S_IDLE;
            cursor_reg    <= '0;
            valid_reg     <= '0;
            cap_reg       <= bfsb_pkg::CAP_RESET;
            mode_reg      <= bfsb_pkg::MODE_RW;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            valid_reg     <= valid_next;
            cap_reg       <= cap_next;
            mode_reg      <= mode_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rval_reg   <= rval_next;
        status_reg <= status_next;
    end

    // Result channel. Cursor and size are live registers that hold still
    // until the next command is taken, which needs the result transferred.
    assign out_ch.valid           = out_valid_reg;
    assign out_ch.read_value      = rval_reg;
    assign out_ch.cursor_position = cursor_reg;
    assign out_ch.data_size_bits  = valid_reg;
    assign out_ch.status          = status_reg;

    // The cursor never runs past the data, and the data never past the store.
    `BFSB_ASSERT_IMPL(a_cursor_in_data, 1'b1, cursor_reg <= valid_reg)
    `BFSB_ASSERT_IMPL(a_data_in_store, 1'b1, 32'(valid_reg) <= 32'(STORE_BITS))
    // A transferred command executes in the next cycle and leaves a result.
    `BFSB_ASSERT_NEXT(a_fire_to_exec, in_fire, state_reg == bfsb_pkg::S_EXEC)
    `BFSB_ASSERT_NEXT(a_exec_to_result, exec_en, out_valid_reg)
    // No new command while one is executing.
    `BFSB_ASSERT_IMPL(a_no_take_in_exec, exec_en, !in_ready)

endmodule

`default_nettype wire

FILE: tb/sv/bfsb_stream_check.sv
// Watches the command and result channels of the bit field stream buffer.
// It keeps its own image of the store, the cursor, the data size and the
// two registers, works out the result of every command transfer and compares
// each result transfer with the oldest outcome still awaited.
module bfsb_stream_check
    import bfsb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    bfsb_in_if                    in_ch,
    bfsb_out_if                   out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    awaited_count,
    output int                    results_checked,
    output int                    refusals_seen,
    output logic [POS_W-1:0]      cursor_now,
    output logic [POS_W-1:0]      size_now
);

    localparam int STORE_BYTES    = STORE_BYTES_DEF;
    localparam int MAX_FIELD_BITS = MAX_FIELD_BITS_DEF;
    localparam int PRINT_LIMIT    = 40;

    typedef struct packed {
        op_t                 op;
        logic [VALUE_W-1:0]  value;
        logic [LENGTH_W-1:0] length;
        logic [POS_W-1:0]    position;
    } command_t;

    typedef struct packed {
        logic [VALUE_W-1:0] read_value;
        logic [POS_W-1:0]   cursor;
        logic [POS_W-1:0]   size;
        status_t            status;
    } outcome_t;

    // Image of the buffer as seen through the accepted commands.
    logic [7:0]  store_image [STORE_BYTES];
    int unsigned bit_pos      = 0;
    int unsigned data_bits    = 0;
    int unsigned capacity     = CAP_RESET;
    mode_t       access_mode  = MODE_RW;
    outcome_t    awaited_outcomes [$];

    int mismatch_total = 0;
    int awaited_total  = 0;
    int checked_total  = 0;
    int refused_total  = 0;

    assign fail_count      = mismatch_total;
    assign awaited_count   = awaited_total;
    assign results_checked = checked_total;
    assign refusals_seen   = refused_total;
    assign cursor_now      = bit_pos[POS_W-1:0];
    assign size_now        = data_bits[POS_W-1:0];

    // Prints one line per failure, up to a limit, and counts every one.
    task automatic report_failure(input string msg);
        if (mismatch_total < PRINT_LIMIT)
            $display("[%0t] ERROR: %s", $time, msg);
        mismatch_total++;
    endtask

    // Applies one command to the image and returns the result it causes.
    task automatic apply_bit_command(input command_t cmd, output outcome_t res);
        int unsigned len;
        int unsigned cap_bits;
        int unsigned p;
        int          i;
        len      = (cmd.length > MAX_FIELD_BITS) ? MAX_FIELD_BITS : cmd.length;
        cap_bits = ((capacity > STORE_BYTES) ? STORE_BYTES : capacity) * 8;
        res.read_value = '0;
        res.status     = ST_OK;
        case (cmd.op)
            OP_WRITE:
            begin
                if (access_mode == MODE_RO || access_mode == MODE_NONE)
                    res.status = ST_FORBID;
                else if (bit_pos + len > cap_bits)
                    res.status = ST_NO_ROOM;
                else
                begin
                    for (i = 0; i < len; i++)
                    begin
                        p = bit_pos + i;
                        store_image[p >> 3][p & 7] = cmd.value[i];
                    end
                    bit_pos += len;
                    if (bit_pos > data_bits)
                        data_bits = bit_pos;
                end
            end
            OP_READ:
            begin
                if (access_mode == MODE_WO || access_mode == MODE_NONE)
                    res.status = ST_FORBID;
                else if (bit_pos + len > data_bits)
                    res.status = ST_PAST_END;
                else
                begin
                    for (i = 0; i < len; i++)
                    begin
                        p = bit_pos + i;
                        res.read_value[i] = store_image[p >> 3][p & 7];
                    end
                    bit_pos += len;
                end
            end
            OP_SEEK:
            begin
                // A seek is allowed in every mode; the data end is checked first.
                if (cmd.position > data_bits)
                    res.status = ST_PAST_END;
                else if (cmd.position > cap_bits)
                    res.status = ST_NO_ROOM;
                else
                    bit_pos = cmd.position;
            end
            default:
            begin
                bit_pos   = 0;
                data_bits = 0;
            end
        endcase
        res.cursor = bit_pos[POS_W-1:0];
        res.size   = data_bits[POS_W-1:0];
    endtask

    // Register writes, result comparison and prediction, all at the rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        command_t cmd;
        outcome_t want;
        outcome_t got;
        if (!rst_n)
        begin
            bit_pos       = 0;
            data_bits     = 0;
            capacity      = CAP_RESET;
            access_mode   = MODE_RW;
            awaited_outcomes.delete();
            awaited_total = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_CAPACITY)
                    capacity = cfg_data;
                else
                    access_mode = mode_t'(cfg_data[MODE_W-1:0]);
            end

            // Result transfer: compare with the oldest awaited outcome.
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            begin
                got.read_value = out_ch.read_value;
                got.cursor     = out_ch.cursor_position;
                got.size       = out_ch.data_size_bits;
                got.status     = status_t'(out_ch.status);
                if (awaited_outcomes.size() == 0)
                    report_failure("result transfer with no command waiting for it");
                else
                begin
                    want = awaited_outcomes.pop_front();
                    if (got.read_value !== want.read_value)
                        report_failure($sformatf("read_value 0x%0h, expected 0x%0h",
                                                 got.read_value, want.read_value));
                    if (got.cursor !== want.cursor)
                        report_failure($sformatf("cursor_position %0d, expected %0d",
                                                 got.cursor, want.cursor));
                    if (got.size !== want.size)
                        report_failure($sformatf("data_size_bits %0d, expected %0d",
                                                 got.size, want.size));
                    if (got.status !== want.status)
                        report_failure($sformatf("status %s, expected %s",
                                                 got.status.name(), want.status.name()));
                    if (want.status != ST_OK)
                        refused_total++;
                end
                checked_total++;
            end

            // Command transfer: predict its result.
            if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
            begin
                cmd.op       = op_t'(in_ch.operation);
                cmd.value    = in_ch.write_value;
                cmd.length   = in_ch.field_length;
                cmd.position = in_ch.new_position;
                apply_bit_command(cmd, want);
                awaited_outcomes.push_back(want);
            end
            awaited_total = awaited_outcomes.size();
        end
    end

endmodule

FILE: tb/sv/tb_bit_field_stream_buffer_top.sv
// Drives the bit field stream buffer with directed and random commands,
// changes the registers between phases and gives the verdict. Prediction
// and comparison happen in the stream checker beside the block.
module tb_bit_field_stream_buffer_top;
    import bfsb_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 8;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SEGMENTS       = 15;
    localparam int SEGMENT_ITEMS  = 70;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int                    fail_count;
    int                    awaited_count;
    int                    results_checked;
    int                    refusals_seen;
    logic [POS_W-1:0]      modeled_cursor;
    logic [POS_W-1:0]      modeled_size;

    int tx_idle_pct      = 36;
    int rx_idle_pct      = 58;
    int commands_sent    = 0;
    int settings_applied = 0;
    int quiet_cycles     = 0;

    bfsb_in_if  cmd_ch ();
    bfsb_out_if res_ch ();

    bit_field_stream_buffer_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (cmd_ch),
        .out_ch    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bfsb_stream_check i_stream_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_ch           (cmd_ch),
        .out_ch          (res_ch),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .awaited_count   (awaited_count),
        .results_checked (results_checked),
        .refusals_seen   (refusals_seen),
        .cursor_now      (modeled_cursor),
        .size_now        (modeled_size)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // The result sink stalls at random, changing ready at the falling edge.
    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            res_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Ends the run when no transfer happens for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Presents one command, with random idle cycles first, and waits for its
    // transfer. Called and returns at a falling edge; valid stays high.
    task automatic send_command(input op_t op, input logic [VALUE_W-1:0] value,
                                input logic [LENGTH_W-1:0] length,
                                input logic [POS_W-1:0] position);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid        <= 1'b1;
        cmd_ch.operation    <= op;
        cmd_ch.write_value  <= value;
        cmd_ch.field_length <= length;
        cmd_ch.new_position <= position;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        @(negedge clk);
        commands_sent++;
    endtask

    // Stops sending and waits until every awaited result has arrived.
    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (awaited_count != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Writes both registers while the block is idle.
    task automatic program_registers(input int unsigned capacity, input mode_t mode);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= REG_CAPACITY;
        cfg_data  <= capacity[CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_index <= REG_MODE;
        cfg_data  <= CFG_DATA_W'(mode);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        settings_applied++;
    endtask

    // Field lengths: mostly ordinary, some empty, full and oversized ones.
    function automatic logic [LENGTH_W-1:0] random_length();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 6)
            return LENGTH_W'($urandom_range(33, 63));
        else if (pick < 12)
            return '0;
        else if (pick < 20)
            return LENGTH_W'(MAX_FIELD_BITS_DEF);
        return LENGTH_W'($urandom_range(1, 31));
    endfunction

    // Mostly well-formed commands that follow the current cursor and data
    // size, with some reads and seeks past the data end as noise.
    task automatic send_random_command();
        int unsigned pick;
        int unsigned avail;
        int unsigned target;
        logic [LENGTH_W-1:0] length;
        pick   = $urandom_range(0, 99);
        length = random_length();
        avail  = modeled_size - modeled_cursor;
        if (pick < 40)
            send_command(OP_WRITE, $urandom, length, POS_W'($urandom_range(0, 65535)));
        else if (pick < 72)
        begin
            if ($urandom_range(0, 99) < 85)
                length = LENGTH_W'($urandom_range(0, (avail < 32) ? avail : 32));
            send_command(OP_READ, $urandom, length, POS_W'($urandom_range(0, 65535)));
        end
        else if (pick < 95)
        begin
            case ($urandom_range(0, 9))
                0:       target = $urandom_range(0, 65535);
                1:       target = modeled_size + $urandom_range(1, 40);
                default: target = $urandom_range(0, modeled_size);
            endcase
            send_command(OP_SEEK, $urandom, length, target[POS_W-1:0]);
        end
        else
            send_command(OP_CLEAR, $urandom, length, POS_W'($urandom_range(0, 65535)));
    endtask

    // Main sequence.
    initial
    begin
        int          seg;
        int unsigned capacity;
        int unsigned pick;
        mode_t       mode;

        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = REG_CAPACITY;
        cfg_data            = '0;
        cmd_ch.valid        = 1'b0;
        cmd_ch.operation    = OP_WRITE;
        cmd_ch.write_value  = '0;
        cmd_ch.field_length = '0;
        cmd_ch.new_position = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty buffer, full fields, oversized length, unaligned access.
        send_command(OP_READ,  32'h0,        6'd0,  16'd0);
        send_command(OP_READ,  32'h0,        6'd1,  16'd0);
        send_command(OP_WRITE, 32'hFFFFFFFF, 6'd32, 16'd0);
        send_command(OP_WRITE, 32'hA5A5A5A5, 6'd45, 16'hFFFF);
        send_command(OP_SEEK,  32'h0,        6'd0,  16'd0);
        send_command(OP_READ,  32'h0,        6'd63, 16'd0);
        send_command(OP_READ,  32'h0,        6'd32, 16'd0);
        send_command(OP_READ,  32'h0,        6'd1,  16'd0);
        send_command(OP_SEEK,  32'h0,        6'd0,  16'hFFFF);
        send_command(OP_SEEK,  32'h0,        6'd0,  16'd3);
        send_command(OP_WRITE, 32'h00012345, 6'd17, 16'd0);
        send_command(OP_SEEK,  32'h0,        6'd0,  16'd1);
        send_command(OP_READ,  32'h0,        6'd31, 16'd0);

        // One byte of room: seek into data beyond it, then fill it exactly.
        program_registers(1, MODE_RW);
        send_command(OP_SEEK,  32'h0,        6'd0,  16'd40);
        send_command(OP_CLEAR, 32'h0,        6'd0,  16'd0);
        send_command(OP_WRITE, 32'h000001FF, 6'd9,  16'd0);
        send_command(OP_WRITE, 32'h000000C3, 6'd8,  16'd0);
        send_command(OP_WRITE, 32'h00000001, 6'd1,  16'd0);

        // No room at all, read only: the mode check comes first.
        program_registers(0, MODE_RO);
        send_command(OP_WRITE, 32'h00000001, 6'd1,  16'd0);
        send_command(OP_SEEK,  32'h0,        6'd0,  16'd0);
        send_command(OP_READ,  32'h0,        6'd8,  16'd0);
        program_registers(0, MODE_RW);
        send_command(OP_WRITE, 32'h00000001, 6'd0,  16'd0);
        send_command(OP_WRITE, 32'h00000001, 6'd1,  16'd0);

        // Capacity above the store size, write only.
        program_registers(13'h1FFF, MODE_WO);
        send_command(OP_READ,  32'h0,        6'd0,  16'd0);
        send_command(OP_WRITE, 32'hDEADBEEF, 6'd32, 16'd0);

        // Neither access allowed; seek and clear still work.
        program_registers(4096, MODE_NONE);
        send_command(OP_WRITE, 32'h12345678, 6'd8,  16'd0);
        send_command(OP_READ,  32'h0,        6'd8,  16'd0);
        send_command(OP_SEEK,  32'h0,        6'd0,  16'd0);
        send_command(OP_CLEAR, 32'h0,        6'd0,  16'd0);

        // Random segments, each under its own register setting.
        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            if (seg == SEGMENTS / 3)
            begin
                tx_idle_pct = 58;
                rx_idle_pct = 36;
            end
            else if (seg == 2 * SEGMENTS / 3)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            case ($urandom_range(0, 7))
                0:       capacity = 0;
                1:       capacity = 1;
                2:       capacity = $urandom_range(2, 16);
                3:       capacity = 4096;
                4:       capacity = 8191;
                5:       capacity = $urandom_range(4097, 8191);
                default: capacity = $urandom_range(17, 4095);
            endcase
            pick = $urandom_range(0, 99);
            if (pick < 65)
                mode = MODE_RW;
            else if (pick < 77)
                mode = MODE_RO;
            else if (pick < 89)
                mode = MODE_WO;
            else
                mode = MODE_NONE;
            program_registers(capacity, mode);
            repeat (SEGMENT_ITEMS) send_random_command();
        end

        drain_results();
        $display("Sent %0d commands under %0d register settings; %0d results checked.",
                 commands_sent, settings_applied, results_checked);
        $display("%0d results were refusals for room, data end or access mode.",
                 refusals_seen);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: bit_field_stream_buffer_top.f
+incdir+rtl/core
rtl/core/bfsb_pkg.sv
rtl/core/bfsb_if.sv
rtl/core/bfsb_ram.sv
rtl/core/bfsb_field_unit.sv
rtl/core/bit_field_stream_buffer_top.sv
tb/sv/bfsb_stream_check.sv
tb/sv/tb_bit_field_stream_buffer_top.sv
